[hdl/ptet_pkg.sv]
`timescale 1ns / 1ps
// Types and constants shared by the threat escalation table modules.
// No dependencies.
package ptet_pkg;

    localparam logic [3:0] K_ALLOC      = 4'd0;
    localparam logic [3:0] K_WRITE      = 4'd1;
    localparam logic [3:0] K_PROTECT    = 4'd2;
    localparam logic [3:0] K_PROTECT_EX = 4'd3;
    localparam logic [3:0] K_THREAD     = 4'd4;
    localparam logic [3:0] K_OTHER      = 4'd5;
    localparam logic [3:0] K_STRUCT     = 4'd6;
    localparam logic [3:0] K_PATCH      = 4'd7;
    localparam logic [3:0] K_SCAN       = 4'd8;
    localparam logic [3:0] K_SIG        = 4'd9;

    localparam int CAP_ALLOC  = 0;
    localparam int CAP_WRITE  = 1;
    localparam int CAP_PROT   = 2;
    localparam int CAP_THREAD = 3;
    localparam int CAP_SIG    = 4;
    localparam int CAP_FROZEN = 5;

    localparam logic [2:0] LVL_NONE = 3'd0;
    localparam logic [2:0] LVL_LOW  = 3'd1;
    localparam logic [2:0] LVL_MED  = 3'd2;
    localparam logic [2:0] LVL_HIGH = 3'd3;
    localparam logic [2:0] LVL_CRIT = 3'd4;

    localparam logic [31:0] EXEC_MASK_RESET = 32'd240;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  eff;
        logic        is_exec;
        logic [31:0] proc_id;
        logic [31:0] prot_bits;
        logic [63:0] address;
        logic [63:0] region_size;
    } t_item;

    typedef struct packed {
        logic  vld;
        t_item item;
    } t_front_q;

    typedef struct packed {
        logic [31:0] proc_id;
        logic [2:0]  level;
        logic [5:0]  caps;
        logic [3:0]  rcnt;
    } t_entry;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] length;
        logic        is_patch;
    } t_region;

    typedef struct packed {
        logic        verdict_valid;
        logic [31:0] verdict_proc;
        logic [1:0]  severity;
        logic [3:0]  trigger_kind;
        logic [31:0] trigger_protect;
        logic        deduplicated;
        logic        table_full;
    } t_result;

endpackage

[hdl/ptet_front.sv]
`timescale 1ns / 1ps
// Front end: accepts event beats, classifies them and queues them.
// Depends on ptet_pkg.
module ptet_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_kind,
    input  logic [31:0]        i_proc_id,
    input  logic [31:0]        i_prot_bits,
    input  logic [63:0]        i_address,
    input  logic [63:0]        i_region_size,
    input  logic [31:0]        i_exec_mask,
    output ptet_pkg::t_front_q o_q,
    input  logic               i_pop
);

    ptet_pkg::t_item r_buf [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    ptet_pkg::t_item n_item;
    logic            push;
    logic            pop;

    always_comb begin
        n_item.kind          = i_kind;
        n_item.eff           = (i_kind > ptet_pkg::K_SIG) ? ptet_pkg::K_OTHER : i_kind;
        n_item.is_exec       = (i_prot_bits & i_exec_mask) != 32'd0;
        n_item.proc_id       = i_proc_id;
        n_item.prot_bits     = i_prot_bits;
        n_item.address       = i_address;
        n_item.region_size   = i_region_size;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_cnt != 2'd0);
    assign o_q.vld    = (r_cnt != 2'd0);
    assign o_q.item   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[hdl/ptet_back.sv]
`timescale 1ns / 1ps
// Back end: entry lookup scan, region match scan, flag update and verdict.
// Depends on ptet_pkg.
module ptet_back #(
    parameter int TABLE_ENTRIES     = 512,
    parameter int REGIONS_PER_ENTRY = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptet_pkg::t_front_q i_q,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ptet_pkg::t_result  o_res
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int RW = (REGIONS_PER_ENTRY > 1) ? $clog2(REGIONS_PER_ENTRY) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_REG  = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    ptet_pkg::t_entry  m_ent [TABLE_ENTRIES];
    ptet_pkg::t_region m_reg [TABLE_ENTRIES << RW];

    t_state            r_state;
    ptet_pkg::t_item   r_it;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_fill;
    logic              r_q_vld;
    logic [IW-1:0]     r_q_idx;
    ptet_pkg::t_entry  r_ent_q;
    logic [IW-1:0]     r_e;
    ptet_pkg::t_entry  r_cur;
    logic              r_full;
    logic              r_skip;
    logic [3:0]        r_ri;
    logic              r_rq_vld;
    ptet_pkg::t_region r_reg_q;
    logic              r_out_vld;
    ptet_pkg::t_result r_out;

    ptet_pkg::t_entry  n_ent;
    ptet_pkg::t_result n_res;
    logic [5:0]        n_caps;
    logic [2:0]        n_lvl;
    logic              n_rec;
    logic              hit;
    logic              rmatch;
    logic [63:0]       roff;
    logic              out_free;
    logic              need_reg;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_res       = r_out;
    assign o_pop       = (r_state == S_IDLE) && i_q.vld;
    assign hit         = r_q_vld && (r_ent_q.proc_id == r_it.proc_id);
    assign roff        = r_it.address - r_reg_q.base;
    assign rmatch      = r_rq_vld && r_reg_q.is_patch && (r_it.address >= r_reg_q.base)
                         && (roff < r_reg_q.length);
    assign need_reg    = (r_it.eff == ptet_pkg::K_PATCH) && (r_it.address != 64'd0);

    always_ff @(posedge i_clk) begin
        r_ent_q <= m_ent[r_idx[IW-1:0]];
        r_reg_q <= m_reg[{r_e, r_ri[RW-1:0]}];
        if (r_state == S_UPD && out_free && !r_full && !r_skip) begin
            m_ent[r_e] <= n_ent;
            if (n_rec) begin
                m_reg[{r_e, r_cur.rcnt[RW-1:0]}] <= '{base: r_it.address,
                    length: r_it.region_size, is_patch: (r_it.eff != ptet_pkg::K_ALLOC)};
            end
        end
    end

    always_comb begin
        n_caps = r_cur.caps;
        n_rec  = (r_it.eff <= ptet_pkg::K_PROTECT) && (r_it.address != 64'd0)
                 && (r_it.region_size != 64'd0) && (r_cur.rcnt < 4'(REGIONS_PER_ENTRY));
        unique case (r_it.eff)
            ptet_pkg::K_ALLOC: begin
                n_caps[ptet_pkg::CAP_ALLOC] = 1'b1;
                if (r_it.is_exec) begin
                    n_caps[ptet_pkg::CAP_PROT] = 1'b1;
                end
            end
            ptet_pkg::K_WRITE: begin
                if (r_cur.caps[ptet_pkg::CAP_ALLOC]) begin
                    n_caps[ptet_pkg::CAP_WRITE] = 1'b1;
                end
            end
            ptet_pkg::K_PROTECT, ptet_pkg::K_PROTECT_EX: begin
                if (r_it.is_exec) begin
                    n_caps[ptet_pkg::CAP_PROT] = 1'b1;
                end
            end
            ptet_pkg::K_THREAD: n_caps[ptet_pkg::CAP_THREAD] = 1'b1;
            ptet_pkg::K_STRUCT: begin
                n_caps[ptet_pkg::CAP_WRITE] = 1'b1;
                n_caps[ptet_pkg::CAP_PROT]  = 1'b1;
            end
            ptet_pkg::K_PATCH, ptet_pkg::K_SCAN: n_caps[ptet_pkg::CAP_PROT] = 1'b1;
            ptet_pkg::K_SIG: n_caps[ptet_pkg::CAP_SIG] = 1'b1;
            default: ;
        endcase

        if (n_caps[ptet_pkg::CAP_THREAD] || n_caps[ptet_pkg::CAP_SIG]) begin
            n_lvl = ptet_pkg::LVL_CRIT;
        end else if (n_caps[ptet_pkg::CAP_WRITE] && n_caps[ptet_pkg::CAP_PROT]) begin
            n_lvl = ptet_pkg::LVL_HIGH;
        end else if (n_caps[ptet_pkg::CAP_WRITE] || n_caps[ptet_pkg::CAP_PROT]) begin
            n_lvl = ptet_pkg::LVL_MED;
        end else if (n_caps[ptet_pkg::CAP_ALLOC]) begin
            n_lvl = ptet_pkg::LVL_LOW;
        end else begin
            n_lvl = ptet_pkg::LVL_NONE;
        end

        n_ent         = r_cur;
        n_ent.rcnt    = r_cur.rcnt + {3'd0, n_rec};
        n_res         = '0;
        n_res.deduplicated = r_skip;
        n_res.table_full   = r_full;
        if (!r_full && !r_skip && !r_cur.caps[ptet_pkg::CAP_FROZEN]
                && n_lvl != ptet_pkg::LVL_NONE && n_lvl > r_cur.level) begin
            n_ent.level = n_lvl;
            if (n_lvl == ptet_pkg::LVL_CRIT) begin
                n_caps[ptet_pkg::CAP_FROZEN] = 1'b1;
            end
            n_res.verdict_valid = 1'b1;
            n_res.verdict_proc  = r_it.proc_id;
            n_res.severity      = 2'(n_lvl - 3'd1);
            n_res.trigger_kind  = r_it.kind;
            if (r_it.eff == ptet_pkg::K_PROTECT || r_it.eff == ptet_pkg::K_PROTECT_EX) begin
                n_res.trigger_protect = r_it.prot_bits;
            end
        end
        n_ent.caps = n_caps;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it <= i_q.item;
        end
        if (r_state == S_UPD && out_free) begin
            r_out <= n_res;
        end
        if (r_state == S_SCAN) begin
            if (hit) begin
                r_cur <= r_ent_q;
                r_e   <= r_q_idx;
            end else if (!(r_idx < r_fill)) begin
                r_cur <= '{proc_id: r_it.proc_id, level: 3'd0, caps: 6'd0, rcnt: 4'd0};
                r_e   <= r_fill[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_q_vld   <= 1'b0;
            r_q_idx   <= '0;
            r_full    <= 1'b0;
            r_skip    <= 1'b0;
            r_ri      <= '0;
            r_rq_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_UPD && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q.vld) begin
                        r_idx   <= '0;
                        r_q_vld <= 1'b0;
                        r_full  <= 1'b0;
                        r_skip  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_ri     <= '0;
                    r_rq_vld <= 1'b0;
                    if (hit) begin
                        r_q_vld <= 1'b0;
                        r_state <= need_reg ? S_REG : S_UPD;
                    end else if (r_idx < r_fill) begin
                        r_q_vld <= 1'b1;
                        r_q_idx <= r_idx[IW-1:0];
                        r_idx   <= r_idx + CW'(1);
                    end else begin
                        r_q_vld <= 1'b0;
                        if (r_fill == CW'(TABLE_ENTRIES)) begin
                            r_full <= 1'b1;
                        end else begin
                            r_fill <= r_fill + CW'(1);
                        end
                        r_state <= S_UPD;
                    end
                end
                S_REG: begin
                    if (rmatch) begin
                        r_skip  <= 1'b1;
                        r_state <= S_UPD;
                    end else if (r_ri < r_cur.rcnt) begin
                        r_rq_vld <= 1'b1;
                        r_ri     <= r_ri + 4'd1;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/per_process_threat_escalation_table.sv]
`timescale 1ns / 1ps
// Per-process threat escalation table, top level.
// Depends on ptet_pkg, ptet_front and ptet_back.
//
// Input channel: one security event per beat (i_in_valid / o_in_stall).
// Output channel: exactly one result beat per event (o_out_valid / i_out_stall).
// Config channel: i_cfg_valid / o_cfg_ready writes exec_mask; write only when idle.
// The front end queues up to two events while the back end works.
// In the back end, the lookup scan reads the process entries in use one per
// cycle from the entry memory, and the recorded regions of the entry are read
// one per cycle, only for local patch findings with a nonzero address.
// Reset empties the table (fill count to zero) and sets exec_mask to 240;
// no clearing pass is needed. When the receiver stalls, the finished result
// holds in the output register and the back end waits with its next result.
module per_process_threat_escalation_table #(
    parameter int TABLE_ENTRIES     = 512,
    parameter int REGIONS_PER_ENTRY = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_kind,
    input  logic [31:0] i_proc_id,
    input  logic [31:0] i_prot_bits,
    input  logic [63:0] i_address,
    input  logic [63:0] i_region_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_verdict_valid,
    output logic [31:0] o_verdict_proc,
    output logic [1:0]  o_severity,
    output logic [3:0]  o_trigger_kind,
    output logic [31:0] o_trigger_protect,
    output logic        o_deduplicated,
    output logic        o_table_full,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]        r_exec_mask;
    ptet_pkg::t_front_q q;
    logic               pop;
    ptet_pkg::t_result  res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec_mask <= ptet_pkg::EXEC_MASK_RESET;
        end else if (i_cfg_valid) begin
            r_exec_mask <= i_cfg_data;
        end
    end

    ptet_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_proc_id       (i_proc_id),
        .i_prot_bits     (i_prot_bits),
        .i_address       (i_address),
        .i_region_size   (i_region_size),
        .i_exec_mask     (r_exec_mask),
        .o_q             (q),
        .i_pop           (pop)
    );

    ptet_back #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .REGIONS_PER_ENTRY (REGIONS_PER_ENTRY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_verdict_valid   = res.verdict_valid;
    assign o_verdict_proc    = res.verdict_proc;
    assign o_severity        = res.severity;
    assign o_trigger_kind    = res.trigger_kind;
    assign o_trigger_protect = res.trigger_protect;
    assign o_deduplicated    = res.deduplicated;
    assign o_table_full      = res.table_full;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for per_process_threat_escalation_table.
// Drives security events, predicts each result beat in place, compares fields.
// Depends on ptet_pkg and the block's RTL.
module testbench;

    localparam int ENTRIES   = 512;
    localparam int REGIONS   = 8;
    localparam int WD_LIMIT  = 20000;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] pid;
        logic [31:0] prot;
        logic [63:0] addr;
        logic [63:0] size;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    logic [3:0]  in_kind = '0;
    logic [31:0] in_pid = '0;
    logic [31:0] in_prot = '0;
    logic [63:0] in_addr = '0;
    logic [63:0] in_size = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    ptet_pkg::t_result got;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] cfg_data = '0;

    t_event      pending[$];
    t_event      cur;
    ptet_pkg::t_result verdicts_due[$];
    int          send_idle = 0;
    int          recv_stall = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    logic [31:0] exec_mask;
    int          used_n;
    logic [31:0] tbl_pid[ENTRIES];
    logic [2:0]  tbl_lvl[ENTRIES];
    logic [5:0]  tbl_caps[ENTRIES];
    int          tbl_nreg[ENTRIES];
    logic [63:0] rg_base[ENTRIES][REGIONS];
    logic [63:0] rg_len[ENTRIES][REGIONS];
    bit          rg_patch[ENTRIES][REGIONS];

    logic [31:0] pid_pool[$];
    logic [63:0] patch_base[$];
    logic [63:0] patch_len[$];

    always #10 i_clk = ~i_clk;

    per_process_threat_escalation_table DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (in_kind),
        .i_proc_id        (in_pid),
        .i_prot_bits      (in_prot),
        .i_address        (in_addr),
        .i_region_size    (in_size),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_verdict_valid  (got.verdict_valid),
        .o_verdict_proc   (got.verdict_proc),
        .o_severity       (got.severity),
        .o_trigger_kind   (got.trigger_kind),
        .o_trigger_protect(got.trigger_protect),
        .o_deduplicated   (got.deduplicated),
        .o_table_full     (got.table_full),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    function automatic ptet_pkg::t_result escalate(input t_event ev);
        ptet_pkg::t_result r;
        int         slot;
        int         i;
        int         n;
        bit         hit;
        bit         is_exec;
        logic [3:0] eff;
        logic [5:0] c;
        logic [2:0] lvl;
        r = '0;
        slot = -1;
        hit = 1'b0;
        eff = (ev.kind > ptet_pkg::K_SIG) ? ptet_pkg::K_OTHER : ev.kind;
        is_exec = (ev.prot & exec_mask) != 0;
        for (i = 0; i < used_n; i++) begin
            if (slot < 0 && tbl_pid[i] == ev.pid) slot = i;
        end
        if (slot < 0 && used_n < ENTRIES) begin
            slot = used_n;
            used_n++;
            tbl_pid[slot] = ev.pid;
            tbl_lvl[slot] = ptet_pkg::LVL_NONE;
            tbl_caps[slot] = '0;
            tbl_nreg[slot] = 0;
        end
        if (slot < 0) begin
            r.table_full = 1'b1;
            return r;
        end
        c = tbl_caps[slot];
        n = tbl_nreg[slot];
        if (eff <= ptet_pkg::K_PROTECT && ev.addr != 0 && ev.size != 0 && n < REGIONS) begin
            rg_base[slot][n] = ev.addr;
            rg_len[slot][n] = ev.size;
            rg_patch[slot][n] = (eff != ptet_pkg::K_ALLOC);
            tbl_nreg[slot] = n + 1;
        end
        case (eff)
            ptet_pkg::K_ALLOC: begin
                c[ptet_pkg::CAP_ALLOC] = 1'b1;
                if (is_exec) c[ptet_pkg::CAP_PROT] = 1'b1;
            end
            ptet_pkg::K_WRITE: if (c[ptet_pkg::CAP_ALLOC]) c[ptet_pkg::CAP_WRITE] = 1'b1;
            ptet_pkg::K_PROTECT, ptet_pkg::K_PROTECT_EX:
                if (is_exec) c[ptet_pkg::CAP_PROT] = 1'b1;
            ptet_pkg::K_THREAD: c[ptet_pkg::CAP_THREAD] = 1'b1;
            ptet_pkg::K_STRUCT: begin
                c[ptet_pkg::CAP_WRITE] = 1'b1;
                c[ptet_pkg::CAP_PROT] = 1'b1;
            end
            ptet_pkg::K_PATCH: begin
                if (ev.addr != 0) begin
                    for (i = 0; i < n; i++) begin
                        if (rg_patch[slot][i] && ev.addr >= rg_base[slot][i] &&
                            ev.addr - rg_base[slot][i] < rg_len[slot][i]) hit = 1'b1;
                    end
                end
                if (!hit) c[ptet_pkg::CAP_PROT] = 1'b1;
            end
            ptet_pkg::K_SCAN: c[ptet_pkg::CAP_PROT] = 1'b1;
            ptet_pkg::K_SIG: c[ptet_pkg::CAP_SIG] = 1'b1;
            default: ;
        endcase
        if (hit) begin
            r.deduplicated = 1'b1;
            return r;
        end
        tbl_caps[slot] = c;
        if (c[ptet_pkg::CAP_FROZEN]) return r;
        if (c[ptet_pkg::CAP_THREAD] || c[ptet_pkg::CAP_SIG]) lvl = ptet_pkg::LVL_CRIT;
        else if (c[ptet_pkg::CAP_WRITE] && c[ptet_pkg::CAP_PROT]) lvl = ptet_pkg::LVL_HIGH;
        else if (c[ptet_pkg::CAP_WRITE] || c[ptet_pkg::CAP_PROT]) lvl = ptet_pkg::LVL_MED;
        else if (c[ptet_pkg::CAP_ALLOC]) lvl = ptet_pkg::LVL_LOW;
        else lvl = ptet_pkg::LVL_NONE;
        if (lvl == ptet_pkg::LVL_NONE || lvl <= tbl_lvl[slot]) return r;
        tbl_lvl[slot] = lvl;
        if (lvl == ptet_pkg::LVL_CRIT) tbl_caps[slot][ptet_pkg::CAP_FROZEN] = 1'b1;
        r.verdict_valid = 1'b1;
        r.verdict_proc = ev.pid;
        r.severity = 2'(lvl - 3'd1);
        r.trigger_kind = ev.kind;
        r.trigger_protect = (eff == ptet_pkg::K_PROTECT || eff == ptet_pkg::K_PROTECT_EX)
                            ? ev.prot : '0;
        return r;
    endfunction

    // Driver: hold the beat while stalled, advance on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) verdicts_due.push_back(escalate(cur));
            if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                cur = pending.pop_front();
                in_kind <= cur.kind;
                in_pid <= cur.pid;
                in_prot <= cur.prot;
                in_addr <= cur.addr;
                in_size <= cur.size;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic mismatch(input string field, input logic [63:0] e, input logic [63:0] a);
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, e, a);
    endtask

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        ptet_pkg::t_result e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, actual %0h", $time, got);
            end else begin
                e = verdicts_due.pop_front();
                if (got.verdict_valid !== e.verdict_valid)
                    mismatch("verdict_valid", e.verdict_valid, got.verdict_valid);
                if (got.verdict_proc !== e.verdict_proc)
                    mismatch("verdict_proc", e.verdict_proc, got.verdict_proc);
                if (got.severity !== e.severity)
                    mismatch("severity", e.severity, got.severity);
                if (got.trigger_kind !== e.trigger_kind)
                    mismatch("trigger_kind", e.trigger_kind, got.trigger_kind);
                if (got.trigger_protect !== e.trigger_protect)
                    mismatch("trigger_protect", e.trigger_protect, got.trigger_protect);
                if (got.deduplicated !== e.deduplicated)
                    mismatch("deduplicated", e.deduplicated, got.deduplicated);
                if (got.table_full !== e.table_full)
                    mismatch("table_full", e.table_full, got.table_full);
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_mask(input logic [31:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        exec_mask = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending.size() > 0 || in_valid || verdicts_due.size() > 0);
    endtask

    task automatic send(input logic [3:0] k, input logic [31:0] p, input logic [31:0] f,
                        input logic [63:0] a, input logic [63:0] s);
        t_event ev;
        ev.kind = k;
        ev.pid = p;
        ev.prot = f;
        ev.addr = a;
        ev.size = s;
        pending.push_back(ev);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_event(input logic [31:0] p);
        int          r;
        int          j;
        logic [3:0]  k;
        logic [63:0] a;
        logic [63:0] s;
        logic [31:0] f;
        r = $urandom_range(99);
        a = ($urandom_range(9) == 0) ? 64'd0 : rand64();
        case ($urandom_range(3))
            0: s = 64'd0;
            1: s = 64'(1 + $urandom_range(4095));
            2: s = rand64();
            default: s = 64'(1 + $urandom_range(255));
        endcase
        case ($urandom_range(3))
            0: f = '0;
            1: f = 32'h1 << $urandom_range(31);
            default: f = $urandom;
        endcase
        if (r < 14) k = ptet_pkg::K_ALLOC;
        else if (r < 30) k = ptet_pkg::K_WRITE;
        else if (r < 42) k = ptet_pkg::K_PROTECT;
        else if (r < 48) k = ptet_pkg::K_PROTECT_EX;
        else if (r < 52) k = ptet_pkg::K_THREAD;
        else if (r < 55) k = ptet_pkg::K_OTHER;
        else if (r < 58) k = 4'($urandom_range(10, 15));
        else if (r < 63) k = ptet_pkg::K_STRUCT;
        else if (r < 82) k = ptet_pkg::K_PATCH;
        else if (r < 92) k = ptet_pkg::K_SCAN;
        else k = ptet_pkg::K_SIG;
        if ((k == ptet_pkg::K_WRITE || k == ptet_pkg::K_PROTECT) && a != 0 && s != 0) begin
            patch_base.push_back(a);
            patch_len.push_back(s);
            if (patch_base.size() > 32) begin
                void'(patch_base.pop_front());
                void'(patch_len.pop_front());
            end
        end
        if (k == ptet_pkg::K_PATCH && patch_base.size() > 0 && $urandom_range(1)) begin
            j = $urandom_range(patch_base.size() - 1);
            a = patch_base[j] + (rand64() % patch_len[j]);
        end
        send(k, p, f, a, s);
    endtask

    task automatic random_phase(input int count);
        int j;
        repeat (count) begin
            if (pid_pool.size() < 4 || $urandom_range(99) < 12) begin
                if (pid_pool.size() >= 24) pid_pool.delete($urandom_range(23));
                pid_pool.push_back($urandom);
            end
            j = $urandom_range(pid_pool.size() - 1);
            random_event(pid_pool[j]);
        end
        drain();
    endtask

    initial begin
        exec_mask = ptet_pkg::EXEC_MASK_RESET;
        used_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 8;
        recv_stall = 72;
        write_mask(32'h0000_00F0);
        send(ptet_pkg::K_ALLOC, 32'h0, 32'h1, 64'h1000, 64'h100);
        send(ptet_pkg::K_WRITE, 32'h0, 32'h0, 64'h2000, 64'h100);
        send(ptet_pkg::K_PATCH, 32'h0, 32'h0, 64'h20FF, 64'h0);
        send(ptet_pkg::K_PATCH, 32'h0, 32'h0, 64'h1010, 64'h0);
        send(ptet_pkg::K_PROTECT, 32'h0, 32'h40, 64'h0, 64'h0);
        send(ptet_pkg::K_PATCH, 32'h0, 32'h0, 64'h0, 64'h0);
        send(ptet_pkg::K_THREAD, 32'h0, 32'h0, 64'h0, 64'h0);
        send(ptet_pkg::K_SIG, 32'h0, 32'h0, 64'h0, 64'h0);
        send(ptet_pkg::K_WRITE, 32'hFFFF_FFFF, 32'h0, 64'h10, 64'h10);
        send(ptet_pkg::K_PROTECT_EX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 64'h0);
        send(ptet_pkg::K_OTHER, 32'hFFFF_FFFF, 32'h0, 64'h0, 64'h0);
        send(4'd15, 32'hFFFF_FFFF, 32'h0, 64'h0, 64'h0);
        send(ptet_pkg::K_SCAN, 32'hFFFF_FFFF, 32'h0, 64'h0, 64'h0);
        send(ptet_pkg::K_STRUCT, 32'hFFFF_FFFF, 32'h0, 64'h0, 64'h0);
        send(ptet_pkg::K_PROTECT, 32'h5, 32'h0, 64'hFFFF_FFFF_FFFF_F000,
             64'hFFFF_FFFF_FFFF_FFFF);
        send(ptet_pkg::K_PATCH, 32'h5, 32'h0, 64'h10, 64'h0);
        send(ptet_pkg::K_PATCH, 32'h5, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        for (int i = 0; i < REGIONS; i++)
            send(ptet_pkg::K_WRITE, 32'h6, 32'h0, 64'h100 * (i + 1), 64'h10);
        send(ptet_pkg::K_PATCH, 32'h6, 32'h0, 64'h905, 64'h0);
        drain();

        write_mask(32'h0);
        random_phase(200);
        send_idle = 72;
        recv_stall = 8;
        write_mask(32'hFFFF_FFFF);
        random_phase(200);
        send_idle = 0;
        recv_stall = 0;
        write_mask($urandom);
        random_phase(200);

        // Fill the table with fresh processes, then keep going past full.
        send_idle = 8;
        recv_stall = 72;
        write_mask(ptet_pkg::EXEC_MASK_RESET);
        repeat (ENTRIES - used_n + 30) random_event($urandom);
        drain();
        send_idle = 0;
        recv_stall = 0;
        random_phase(60);

        repeat (600) @(posedge i_clk);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
